/* design/tdf_pkg.sv */
// Shared constants for the trial-division factorizer.
// No dependencies; imported by trial_division_factorizer and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package tdf_pkg;

    // Width and ceiling of the multiplicity field.
    localparam int POWER_W   = 5;
    localparam logic [POWER_W-1:0] POWER_MAX = 5'd31;

    // At most this many factors are reported for one value.
    localparam int FACTOR_CNT_W = 4;
    localparam logic [FACTOR_CNT_W-1:0] MAX_FACTORS = 4'd9;

    typedef logic [FACTOR_CNT_W-1:0] factor_cnt_t;
    typedef logic [POWER_W-1:0]      power_t;

endpackage : tdf_pkg

`default_nettype wire

/* design/trial_division_factorizer.sv */
// Prime factorizer by trial division, with a bit-serial restoring divider.
// Depends on tdf_pkg for the power width and the factor limit.
`timescale 1ns / 1ps
`default_nettype none

// One value is taken per s_ beat and its prime factors leave on the m_ side
// in ascending order, one beat per distinct prime carrying the prime and its
// multiplicity, with m_tlast on the final factor. Values 0 and 1 give no
// beats. The block is busy (s_tready low) from acceptance until its last
// factor beat is taken. All arithmetic runs through one restoring divider
// that retires one quotient bit per cycle, so each trial division steps
// through every bit of the value, and a candidate divisor that does not
// divide also passes through the check and evaluation states. Candidates
// are 2 and the odd numbers up to the square root of the remaining
// cofactor, so a prime input near 2^31 takes roughly 23,000 candidates;
// small or smooth values finish far sooner.
module trial_division_factorizer
    import tdf_pkg::*;
#(
    parameter int VALUE_WIDTH = 31
) (
    input  wire logic aclk,
    input  wire logic aresetn,

    input  wire logic                                      s_tvalid,
    output logic                                           s_tready,
    // Fields from bit 0: value
    input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0]          s_tdata,

    output logic                                           m_tvalid,
    input  wire logic                                      m_tready,
    // Fields from bit 0: prime, power
    output logic [((VALUE_WIDTH+POWER_W+7)/8)*8-1:0]       m_tdata,
    output logic                                           m_tlast
);

    localparam int M_TDATA_W = ((VALUE_WIDTH + POWER_W + 7) / 8) * 8;
    localparam int SQ_W      = VALUE_WIDTH + 2;
    localparam int BIT_W     = $clog2(VALUE_WIDTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_EVAL  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [VALUE_WIDTH-1:0] rem_reg,   rem_next;    // cofactor still to factor
    logic [VALUE_WIDTH-1:0] div_reg,   div_next;    // trial divisor
    logic [SQ_W-1:0]        sq_reg,    sq_next;     // div_reg squared
    power_t                 exp_reg,   exp_next;
    factor_cnt_t            cnt_reg,   cnt_next;
    logic [VALUE_WIDTH-1:0] quo_reg,   quo_next;    // dividend in, quotient out
    logic [VALUE_WIDTH-1:0] part_reg,  part_next;   // partial remainder
    logic [BIT_W-1:0]       bit_reg,   bit_next;
    logic [VALUE_WIDTH-1:0] prime_reg, prime_next;
    power_t                 power_reg, power_next;
    logic                   last_reg,  last_next;

    logic [VALUE_WIDTH-1:0] in_value;
    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH:0]   trial_diff;
    logic [VALUE_WIDTH-1:0] div_adv;
    logic [SQ_W-1:0]        sq_adv;
    logic                   rem_gt_one;

    assign in_value   = s_tdata[VALUE_WIDTH-1:0];
    assign rem_gt_one = (rem_reg > VALUE_WIDTH'(1));

    // One restoring step: shift in the next dividend bit and try to subtract.
    assign trial      = {part_reg, quo_reg[VALUE_WIDTH-1]};
    assign trial_diff = trial - {1'b0, div_reg};

    // Next candidate: 2 goes to 3, then odd numbers; the square follows by
    // (d + 2)^2 = d^2 + 4d + 4.
    always_comb begin
        if (div_reg == VALUE_WIDTH'(2)) begin
            div_adv = VALUE_WIDTH'(3);
            sq_adv  = SQ_W'(9);
        end else begin
            div_adv = div_reg + VALUE_WIDTH'(2);
            sq_adv  = sq_reg + {div_reg, 2'b00} + SQ_W'(4);
        end
    end

    always_comb begin
        state_next = state_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        sq_next    = sq_reg;
        exp_next   = exp_reg;
        cnt_next   = cnt_reg;
        quo_next   = quo_reg;
        part_next  = part_reg;
        bit_next   = bit_reg;
        prime_next = prime_reg;
        power_next = power_reg;
        last_next  = last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    rem_next = in_value;
                    div_next = VALUE_WIDTH'(2);
                    sq_next  = SQ_W'(4);
                    exp_next = '0;
                    cnt_next = '0;
                    if (in_value > VALUE_WIDTH'(1)) begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (cnt_reg != MAX_FACTORS && rem_gt_one) begin
                    if (sq_reg <= {2'b00, rem_reg}) begin
                        quo_next   = rem_reg;
                        part_next  = '0;
                        bit_next   = BIT_W'(VALUE_WIDTH - 1);
                        state_next = ST_DIV;
                    end else begin
                        // The cofactor left over is prime.
                        prime_next = rem_reg;
                        power_next = power_t'(1);
                        last_next  = 1'b1;
                        state_next = ST_OUT;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (!trial_diff[VALUE_WIDTH]) begin
                    part_next = trial_diff[VALUE_WIDTH-1:0];
                    quo_next  = {quo_reg[VALUE_WIDTH-2:0], 1'b1};
                end else begin
                    part_next = trial[VALUE_WIDTH-1:0];
                    quo_next  = {quo_reg[VALUE_WIDTH-2:0], 1'b0};
                end
                bit_next = bit_reg - BIT_W'(1);
                if (bit_reg == '0) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (part_reg == '0) begin
                    // Divides evenly: keep the quotient and try the same divisor.
                    rem_next   = quo_reg;
                    quo_next   = quo_reg;
                    part_next  = '0;
                    bit_next   = BIT_W'(VALUE_WIDTH - 1);
                    if (exp_reg != POWER_MAX) begin
                        exp_next = exp_reg + power_t'(1);
                    end
                    state_next = ST_DIV;
                end else if (exp_reg != '0) begin
                    prime_next = div_reg;
                    power_next = exp_reg;
                    last_next  = (rem_reg == VALUE_WIDTH'(1)) ||
                                 (cnt_reg == MAX_FACTORS - factor_cnt_t'(1));
                    state_next = ST_OUT;
                end else begin
                    div_next   = div_adv;
                    sq_next    = sq_adv;
                    state_next = ST_CHECK;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    cnt_next = cnt_reg + factor_cnt_t'(1);
                    exp_next = '0;
                    if (last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        div_next   = div_adv;
                        sq_next    = sq_adv;
                        state_next = ST_CHECK;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rem_reg   <= '0;
            div_reg   <= '0;
            sq_reg    <= '0;
            exp_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
            div_reg   <= div_next;
            sq_reg    <= sq_next;
            exp_reg   <= exp_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg   <= quo_next;
        part_reg  <= part_next;
        bit_reg   <= bit_next;
        prime_reg <= prime_next;
        power_reg <= power_next;
        last_reg  <= last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = M_TDATA_W'({power_reg, prime_reg});
    assign m_tlast  = last_reg;

    // A factor beat never carries 0 or 1 as its prime, nor a zero power.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (prime_reg > VALUE_WIDTH'(1)) && (power_reg != '0))
        else $error("factor beat with invalid prime or power");

    // Input and output sides are never open at once.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("accepting a value while a factor beat is pending");

    // The divider runs its full bit count before evaluation.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) && (bit_reg != '0) |=> (state_reg == ST_DIV))
        else $error("divider left before its last bit");

    // A value below two is dropped at once.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (in_value < VALUE_WIDTH'(2)) |=> s_tready)
        else $error("value below two did not return to idle");

endmodule : trial_division_factorizer

`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench for trial_division_factorizer: drives values, predicts
// each factor beat in ascending prime order and compares every m_ beat.
// Depends on tdf_pkg and the trial_division_factorizer RTL.
`timescale 1ns / 1ps

module testbench;
    import tdf_pkg::*;

    localparam int VALUE_WIDTH = 31;
    localparam int S_DATA_W = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int M_DATA_W = ((VALUE_WIDTH + POWER_W + 7) / 8) * 8;
    localparam longint unsigned VALUE_MAX = 64'h7FFF_FFFF;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] prime;
        power_t                 power;
        logic                   last;
    } factor_beat_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;

    factor_beat_t expected_factors [$];
    int           mismatch_count  = 0;
    int           hold_off_cycles = 0;
    bit           no_idle         = 1'b0;

    int small_primes [25] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47,
                              53, 59, 61, 67, 71, 73, 79, 83, 89, 97};

    trial_division_factorizer #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Trial division from 2, then 3 and the odd numbers; a cofactor above 1
    // that is left once the divisor passes its square root is a prime.
    function automatic void predict_factorization(input logic [VALUE_WIDTH-1:0] value);
        longint unsigned cofactor;
        longint unsigned trial;
        factor_cnt_t     found;
        power_t          mult;
        factor_beat_t    beat;
        cofactor = 64'(value);
        trial    = 2;
        found    = '0;
        if (cofactor < 2) return;
        while (found < MAX_FACTORS && cofactor > 1 && trial <= cofactor / trial) begin
            if (cofactor % trial == 0) begin
                mult = '0;
                while (cofactor % trial == 0) begin
                    cofactor = cofactor / trial;
                    if (mult < POWER_MAX) mult = mult + 1'b1;
                end
                beat.prime = trial[VALUE_WIDTH-1:0];
                beat.power = mult;
                beat.last  = 1'b0;
                expected_factors.push_back(beat);
                found = found + 1'b1;
            end
            trial = (trial == 2) ? 3 : trial + 2;
        end
        if (found < MAX_FACTORS && cofactor > 1) begin
            beat.prime = cofactor[VALUE_WIDTH-1:0];
            beat.power = power_t'(1);
            beat.last  = 1'b0;
            expected_factors.push_back(beat);
            found = found + 1'b1;
        end
        if (found > 0) expected_factors[expected_factors.size()-1].last = 1'b1;
    endfunction

    // No gap with no_idle set; else most often none, often a short one, now and then a long one.
    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle) return 0;
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    // Values built from small primes keep the search short; a cofactor up to
    // 16 bits or a 20-bit raw value bounds it at a few hundred candidates.
    function automatic logic [S_DATA_W-1:0] make_test_value();
        int              kind;
        longint unsigned acc;
        longint unsigned p;
        kind = $urandom_range(0, 99);
        acc  = 1;
        if (kind < 8) return $urandom_range(0, 3);
        if (kind < 20) return $urandom_range(0, 20'hFFFFF);
        if (kind < 40) begin
            repeat (40) begin
                p = small_primes[$urandom_range(0, 24)];
                if (acc * p <= VALUE_MAX) acc = acc * p;
            end
        end else begin
            repeat ($urandom_range(1, 8)) begin
                p = small_primes[$urandom_range(0, 24)];
                if (acc * p <= VALUE_MAX) acc = acc * p;
            end
            if (kind < 75) begin
                p = $urandom_range(2, 65535);
                if (acc * p <= VALUE_MAX) acc = acc * p;
            end
        end
        return acc[S_DATA_W-1:0];
    endfunction

    // Offers one value, waits for the beat to be taken, records its factors.
    task automatic send_value(input logic [S_DATA_W-1:0] word);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        predict_factorization(word[VALUE_WIDTH-1:0]);
        gap = pick_idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic test_directed_values();
        send_value(0);
        send_value(1);
        send_value(2);
        send_value(3);
        send_value(4);
        send_value(6);
        send_value(32'h4000_0000);       // 2^30: the largest multiplicity
        send_value(1162261467);          // 3^19
        send_value(63001);               // 251^2: divisor squared equals the cofactor
        send_value(65521);               // a prime left over after the search
        send_value(223092870);           // nine distinct primes
        send_value(2007835830);
        send_value(2147483646);
        send_value(32'h8000_0005);       // the pad bit above the value is ignored
        send_value(32'h7FFF_FFFF);       // largest value, itself a prime
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (8) send_value(make_test_value());
        no_idle = 1'b0;
    endtask

    // The receiver stalls long enough that the block sits on a full factor
    // beat while the next values wait at its input.
    task automatic test_output_backpressure();
        hold_off_cycles = 3000;
        no_idle = 1'b1;
        repeat (6) send_value(make_test_value());
        no_idle = 1'b0;
    endtask

    task automatic test_random_values();
        repeat (71) send_value(make_test_value());
    endtask

    initial begin : receiver
        int gap;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off_cycles > 0) begin
                gap = hold_off_cycles;
                hold_off_cycles = 0;
            end else begin
                gap = pick_idle_len();
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin : check_factor_beats
        factor_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_factors.size() == 0) begin
                $error("factor beat with none expected: prime %0d power %0d last %0b",
                       m_tdata[VALUE_WIDTH-1:0], m_tdata[VALUE_WIDTH +: POWER_W], m_tlast);
                mismatch_count++;
            end else begin
                want = expected_factors.pop_front();
                if (m_tdata[VALUE_WIDTH-1:0] !== want.prime) begin
                    $error("prime: expected %0d, actual %0d",
                           want.prime, m_tdata[VALUE_WIDTH-1:0]);
                    mismatch_count++;
                end
                if (m_tdata[VALUE_WIDTH +: POWER_W] !== want.power) begin
                    $error("power: expected %0d, actual %0d",
                           want.power, m_tdata[VALUE_WIDTH +: POWER_W]);
                    mismatch_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0b, actual %0b", want.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #200_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_values();
        test_back_to_back();
        test_output_backpressure();
        test_random_values();
        s_tvalid <= 1'b0;
        while (expected_factors.size() != 0) @(posedge aclk);
        // A trailing value of 0 or 1 may still be in flight; give it time.
        repeat (200) @(posedge aclk);
        if (mismatch_count == 0 && expected_factors.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* sim.f */
design/tdf_pkg.sv
design/trial_division_factorizer.sv
verif/testbench.sv
